>>> rtl/tmd_pkg.sv
// Package for the tile map draw address generator.
// Request codes, register indexes and shared constants. No dependencies.
package tmd_pkg;
  localparam int unsigned MaxTilesets = 8;
  localparam logic [10:0] ColLimit = 11'd1024;

  typedef enum logic [1:0] {
    REQ_TILE   = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_t;

  typedef enum logic [2:0] {
    REG_ORIENT = 3'd0,
    REG_MAP_W  = 3'd1,
    REG_MAP_H  = 3'd2,
    REG_TILE_W = 3'd3,
    REG_TILE_H = 3'd4
  } reg_idx_t;

  localparam logic [1:0] OrientOrtho = 2'd0;
  localparam logic [1:0] OrientIso   = 2'd1;

  // Classified tile item handed from front to back.
  typedef struct packed {
    logic        found;
    logic [5:0]  slot;
    logic [31:0] off;
    logic [15:0] cols;
    logic [19:0] dest_x;
    logic [19:0] dest_y;
  } tile_job_t;
endpackage

>>> rtl/tmd_if.sv
// Valid/ready channel interfaces for the tile map draw address generator.
// Depends on nothing.
interface tmd_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        layer_start;
  logic [31:0] tile_gid;
  logic [31:0] set_first_gid;
  logic [15:0] set_image_width;
  logic [15:0] set_image_height;
  modport source (output valid, req_type, layer_start, tile_gid, set_first_gid,
                  set_image_width, set_image_height, input ready);
  modport sink (input valid, req_type, layer_start, tile_gid, set_first_gid,
                set_image_width, set_image_height, output ready);
endinterface

interface tmd_res_if;
  logic        valid;
  logic        ready;
  logic        drawn;
  logic [2:0]  set_slot;
  logic [19:0] dest_x;
  logic [19:0] dest_y;
  logic [15:0] src_x;
  logic [15:0] src_y;
  modport source (output valid, drawn, set_slot, dest_x, dest_y, src_x, src_y,
                  input ready);
  modport sink (input valid, drawn, set_slot, dest_x, dest_y, src_x, src_y,
                output ready);
endinterface

>>> rtl/tmd_front.sv
// Front part: takes requests, keeps the tileset table and the cursor,
// searches the table and queues classified tiles. Uses tmd_pkg.
module tmd_front import tmd_pkg::*; #(
  parameter int unsigned MAX_TILESETS = MaxTilesets
) (
  input  logic        clk,
  input  logic        rst,
  tmd_req_if.sink     req,
  input  logic [1:0]  orientation,
  input  logic [10:0] map_width_tiles,
  input  logic [10:0] map_height_tiles,
  input  logic [8:0]  tile_width_px,
  input  logic [8:0]  tile_height_px,
  output logic        job_valid,
  input  logic        job_ready,
  output tile_job_t   job
);
  localparam int SW = (MAX_TILESETS > 1) ? $clog2(MAX_TILESETS) : 1;
  localparam int CW = $clog2(MAX_TILESETS + 1);
  localparam logic [CW-1:0] Full = CW'(MAX_TILESETS);

  typedef enum logic [2:0] {
    S_IDLE, S_DIVC, S_DIVR, S_MUL, S_SEARCH, S_ADV
  } state_t;

  state_t      state;
  logic [31:0] first_ids [MAX_TILESETS];
  logic [15:0] columns [MAX_TILESETS];
  logic [31:0] counts [MAX_TILESETS];
  logic [CW-1:0] loaded;
  logic [19:0] cursor_x, cursor_y;
  logic [9:0]  column_count;
  logic [CW-1:0] idx;
  logic [31:0] gid;
  logic [15:0] num, quo, rem_r;
  logic [15:0] cols_r;
  logic [4:0]  bit_cnt;
  logic [15:0] ih;
  logic [8:0]  dv;
  logic [31:0] cnt_r;
  logic        iso;

  logic [16:0] trial;
  logic [15:0] shifted;
  logic [SW-1:0] sidx;
  logic [10:0] wlim;
  logic        row_end;
  logic [19:0] hw20, hh20;

  assign shifted = {rem_r[14:0], num[15]};
  assign trial   = {1'b0, shifted} - {8'd0, dv};
  assign sidx    = SW'(idx - CW'(1));
  assign wlim    = (map_width_tiles > ColLimit) ? ColLimit : map_width_tiles;
  assign row_end = ({1'b0, column_count} + 11'd1 >= wlim);
  assign hw20    = {12'd0, tile_width_px[8:1]};
  assign hh20    = {12'd0, tile_height_px[8:1]};
  assign iso     = (orientation == OrientIso);
  assign req.ready = (state == S_IDLE) && !job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      loaded <= '0;
      cursor_x <= '0;
      cursor_y <= '0;
      column_count <= '0;
      job_valid <= 1'b0;
    end else begin
      if (job_valid && job_ready) job_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.ready) begin
            case (req.req_type)
              REQ_CLEAR: loaded <= '0;
              REQ_APPEND: begin
                if (loaded < Full) begin
                  gid <= req.set_first_gid;
                  num <= req.set_image_width;
                  ih <= req.set_image_height;
                  dv <= tile_width_px;
                  rem_r <= '0;
                  bit_cnt <= '0;
                  state <= S_DIVC;
                end
              end
              REQ_TILE: begin
                gid <= req.tile_gid;
                idx <= loaded;
                job.found <= 1'b0;
                job.slot <= '0;
                job.off <= '0;
                job.cols <= '0;
                if (req.layer_start) begin
                  column_count <= '0;
                  cursor_y <= '0;
                  cursor_x <= iso ? 20'(({9'd0, map_height_tiles} - 20'd1) * hw20) : '0;
                  job.dest_x <= iso ? 20'(({9'd0, map_height_tiles} - 20'd1) * hw20) : '0;
                  job.dest_y <= '0;
                end else begin
                  job.dest_x <= cursor_x;
                  job.dest_y <= cursor_y;
                end
                state <= (orientation <= OrientIso) ? S_SEARCH : S_ADV;
              end
              default: ;
            endcase
          end
        end
        S_DIVC, S_DIVR: begin
          // restoring divide, one quotient bit a cycle; zero divisor gives 0
          quo <= {quo[14:0], !trial[16]};
          if (bit_cnt == 5'd15) begin
            bit_cnt <= '0;
            if (state == S_DIVC) begin
              cols_r <= (dv == '0) ? '0 : {quo[14:0], !trial[16]};
              num <= ih;
              dv <= tile_height_px;
              rem_r <= '0;
              state <= S_DIVR;
            end else begin
              cnt_r <= {16'd0, (dv == '0) ? 16'd0 : {quo[14:0], !trial[16]}};
              state <= S_MUL;
            end
          end else begin
            num <= {num[14:0], 1'b0};
            rem_r <= !trial[16] ? trial[15:0] : shifted;
            bit_cnt <= bit_cnt + 5'd1;
          end
        end
        S_MUL: begin
          first_ids[SW'(loaded)] <= gid;
          columns[SW'(loaded)] <= cols_r;
          counts[SW'(loaded)] <= {16'd0, cols_r} * cnt_r;
          loaded <= loaded + CW'(1);
          state <= S_IDLE;
        end
        S_SEARCH: begin
          if (idx == '0) state <= S_ADV;
          else if (gid >= first_ids[sidx]) begin
            if ((gid - first_ids[sidx]) < counts[sidx] && columns[sidx] != '0) begin
              job.found <= 1'b1;
              job.slot <= 6'(sidx);
              job.off <= gid - first_ids[sidx];
              job.cols <= columns[sidx];
            end
            state <= S_ADV;
          end else idx <= idx - CW'(1);
        end
        S_ADV: begin
          if (orientation <= OrientIso) begin
            column_count <= row_end ? '0 : column_count + 10'd1;
            if (!iso) begin
              if (row_end) begin
                cursor_x <= '0;
                cursor_y <= cursor_y + {11'd0, tile_height_px};
              end else cursor_x <= cursor_x + {11'd0, tile_width_px};
            end else if (row_end) begin
              cursor_x <= cursor_x + hw20 - 20'(({9'd0, wlim} + 20'd1) * hw20);
              cursor_y <= cursor_y + hh20 - 20'(({9'd0, wlim} - 20'd1) * hh20);
            end else begin
              cursor_x <= cursor_x + hw20;
              cursor_y <= cursor_y + hh20;
            end
          end
          job_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) loaded <= Full)
    else $error("tileset count over capacity");
  assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV) |=> job_valid) else $error("tile not queued");
  assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready) |=> $stable(job)) else $error("job changed while held");
endmodule

>>> rtl/tmd_back.sv
// Back part: turns a tile offset into source pixels by an iterative divide
// by the column count, then drives the result register. Uses tmd_pkg.
module tmd_back import tmd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  output logic       job_ready,
  input  tile_job_t  job,
  input  logic [8:0] tile_width_px,
  input  logic [8:0] tile_height_px,
  tmd_res_if.source  res
);
  typedef enum logic [1:0] {S_IDLE, S_DIV, S_MUL} state_t;
  state_t      state;
  tile_job_t   cur;
  logic [31:0] num, quo, rem_r;
  logic [5:0]  bit_cnt;
  logic [32:0] trial;
  logic [31:0] shifted;

  assign shifted   = {rem_r[30:0], num[31]};
  assign trial     = {1'b0, shifted} - {17'd0, cur.cols};
  assign job_ready = (state == S_IDLE) && !res.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res.valid <= 1'b0;
    end else begin
      if (res.valid && res.ready) res.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (job_valid && job_ready) begin
          cur <= job;
          num <= job.off;
          rem_r <= '0;
          bit_cnt <= '0;
          state <= job.found ? S_DIV : S_MUL;
        end
        S_DIV: begin
          num <= {num[30:0], 1'b0};
          if (!trial[32]) begin
            rem_r <= trial[31:0];
            quo <= {quo[30:0], 1'b1};
          end else begin
            rem_r <= shifted;
            quo <= {quo[30:0], 1'b0};
          end
          bit_cnt <= bit_cnt + 6'd1;
          if (bit_cnt == 6'd31) state <= S_MUL;
        end
        S_MUL: begin
          res.drawn <= cur.found;
          res.set_slot <= cur.slot[2:0];
          res.dest_x <= cur.dest_x;
          res.dest_y <= cur.dest_y;
          res.src_x <= cur.found ? 16'(rem_r[15:0] * tile_width_px) : '0;
          res.src_y <= cur.found ? 16'(quo[15:0] * tile_height_px) : '0;
          res.valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL) |=> res.valid) else $error("result not posted");
  assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.drawn) |-> (res.src_x == '0 && res.src_y == '0))
    else $error("undrawn tile has source");
  assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !job_ready) else $error("ready while busy");
endmodule

>>> rtl/tile_map_draw_address_generator.sv
// Tile map draw address generator, top level: APB registers, front and back.
// The front searches the tileset table, one slot a cycle; the back divides the
// offset bit by bit, then posts the result; undrawn tiles skip the divide.
// Appends divide image width and height by tile size in front. Front and back
// overlap through a one-entry queue: the front can classify the next tile while
// the back is busy. Synchronous active-high reset clears table count, cursor.
module tile_map_draw_address_generator import tmd_pkg::*; #(
  parameter int unsigned MAX_TILESETS = MaxTilesets
) (
  input  logic        clk,
  input  logic        rst,
  tmd_req_if.sink     req,
  tmd_res_if.source   res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [1:0]  orientation;
  logic [10:0] map_width_tiles, map_height_tiles;
  logic [8:0]  tile_width_px, tile_height_px;
  logic        job_valid, job_ready;
  tile_job_t   job;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orientation <= 2'd0;
      map_width_tiles <= 11'd1;
      map_height_tiles <= 11'd1;
      tile_width_px <= 9'd32;
      tile_height_px <= 9'd32;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      case (paddr[4:2])
        REG_ORIENT: orientation <= pwdata[1:0];
        REG_MAP_W:  map_width_tiles <= pwdata[10:0];
        REG_MAP_H:  map_height_tiles <= pwdata[10:0];
        REG_TILE_W: tile_width_px <= pwdata[8:0];
        REG_TILE_H: tile_height_px <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORIENT: prdata = {30'd0, orientation};
      REG_MAP_W:  prdata = {21'd0, map_width_tiles};
      REG_MAP_H:  prdata = {21'd0, map_height_tiles};
      REG_TILE_W: prdata = {23'd0, tile_width_px};
      REG_TILE_H: prdata = {23'd0, tile_height_px};
      default:    prdata = '0;
    endcase
  end

  tmd_front #(.MAX_TILESETS(MAX_TILESETS)) u_front (
    .clk, .rst, .req, .orientation, .map_width_tiles, .map_height_tiles,
    .tile_width_px, .tile_height_px, .job_valid, .job_ready, .job
  );

  tmd_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .tile_width_px, .tile_height_px, .res
  );
endmodule
